/* design/pojs_pkg.sv */
// Shared types for the priority order job selector.
package pojs_pkg;

  localparam int unsigned NAME_W  = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned BURST_W = 16;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } job_entry_t;

endpackage

/* design/pojs_if.sv */
// Valid/ready channel interfaces for incoming jobs and emitted results.
interface pojs_job_if;
  logic                           valid;
  logic                           ready;
  logic [pojs_pkg::NAME_W-1:0]    job_name;
  logic [pojs_pkg::PRIO_W-1:0]    job_priority;
  logic [pojs_pkg::BURST_W-1:0]   job_burst;
  logic                           batch_last;

  modport source (output valid, job_name, job_priority, job_burst, batch_last,
                  input ready);
  modport sink (input valid, job_name, job_priority, job_burst, batch_last,
                output ready);
endinterface

interface pojs_res_if;
  logic                           valid;
  logic                           ready;
  logic [pojs_pkg::NAME_W-1:0]    out_name;
  logic [pojs_pkg::PRIO_W-1:0]    out_priority;
  logic [pojs_pkg::BURST_W-1:0]   out_burst;
  logic                           out_last;
  logic                           overflow;

  modport source (output valid, out_name, out_priority, out_burst, out_last, overflow,
                  input ready);
  modport sink (input valid, out_name, out_priority, out_burst, out_last, overflow,
                output ready);
endinterface

/* design/pojs_store.sv */
// Job store: single write port, single registered read port.
module pojs_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  pojs_pkg::job_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output pojs_pkg::job_entry_t rd_data
);

  pojs_pkg::job_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/priority_order_job_selector.sv */
// Top level: loads a batch of jobs and emits them by descending priority.
//
// Usage: jobs arrive on the jobs channel, one transaction per job. Each job
// is written to the store in arrival order; once MAX_JOBS jobs
// are held, further jobs are dropped and the batch is flagged as overflowed.
// A transaction with batch_last set closes the batch: the jobs channel then
// stays not ready until every stored job has left on the results channel.
// Results come out by descending priority, equal priorities in arrival order,
// out_last marks the final one and overflow is the same on all of them.
// Each result needs a scan of the store through its single read port: one
// read per stored job, then the last read is drained and the winner picked.
// The first scan starts after the closing transaction, and a whole batch
// costs one store write per kept job plus one full scan per stored job.
// A stalled receiver simply holds the current result in the output register;
// the next scan starts once it is taken. Reset empties the batch (count,
// taken bits, overflow flag) and returns to loading; the store contents are
// not cleared, since only entries written in the current batch are read.
module priority_order_job_selector #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic         clk,
  input  logic         rst,
  pojs_job_if.sink     jobs,
  pojs_res_if.source   results
);

  localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        job_count;
  logic [CNT_W-1:0]        emitted;
  logic [CNT_W-1:0]        scan_idx;
  logic [MAX_JOBS-1:0]     taken;
  logic                    overflow_seen;

  logic                    rd_valid;
  logic [IDX_W-1:0]        rd_pos;
  logic                    found;
  logic [IDX_W-1:0]        best_pos;
  pojs_pkg::job_entry_t    best;

  logic                    res_valid;
  pojs_pkg::job_entry_t    res_entry;
  logic                    res_last;
  logic                    res_overflow;

  logic                    job_accept;
  logic                    wr_en;
  logic                    rd_en;
  pojs_pkg::job_entry_t    wr_data;
  pojs_pkg::job_entry_t    rd_data;
  logic                    take_best;

  assign jobs.ready  = (state == ST_LOAD);
  assign job_accept  = jobs.valid && jobs.ready;
  assign wr_en       = job_accept && (job_count < CNT_MAX);
  assign wr_data     = '{name: jobs.job_name, prio: jobs.job_priority,
                         burst: jobs.job_burst};
  assign rd_en       = (state == ST_SCAN) && (scan_idx < job_count);

  // A read returning now beats the current best only if untaken and strictly higher.
  assign take_best   = rd_valid && !taken[rd_pos] &&
                       (!found || (rd_data.prio > best.prio));

  pojs_store #(
    .DEPTH (MAX_JOBS),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (job_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      job_count     <= '0;
      emitted       <= '0;
      scan_idx      <= '0;
      taken         <= '0;
      overflow_seen <= 1'b0;
      rd_valid      <= 1'b0;
      found         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (take_best) begin
        best     <= rd_data;
        best_pos <= rd_pos;
        found    <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          if (job_accept) begin
            if (job_count < CNT_MAX) begin
              job_count <= job_count + CNT_ONE;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (jobs.batch_last) begin
              state    <= ST_SCAN;
              scan_idx <= '0;
              found    <= 1'b0;
              rd_valid <= 1'b0;
              emitted  <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + CNT_ONE;
            rd_pos   <= scan_idx[IDX_W-1:0];
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            // Pipeline drained: best holds the winner of this pass.
            if (!rd_valid) begin
              res_entry        <= best;
              res_last         <= (emitted + CNT_ONE == job_count);
              res_overflow     <= overflow_seen;
              res_valid        <= 1'b1;
              taken[best_pos]  <= 1'b1;
              state            <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (results.ready) begin
            res_valid <= 1'b0;
            emitted   <= emitted + CNT_ONE;
            if (res_last) begin
              job_count     <= '0;
              taken         <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_LOAD;
            end else begin
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign results.valid        = res_valid;
  assign results.out_name     = res_entry.name;
  assign results.out_priority = res_entry.prio;
  assign results.out_burst    = res_entry.burst;
  assign results.out_last     = res_last;
  assign results.overflow     = res_overflow;

endmodule
